@@ sv/crcar_pkg.sv @@
// Shared types, constants and the byte-wide CRC update for the checksum appender.
`timescale 1ns / 1ps
package crcar_pkg;

    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET_RST = 32'h1525D2B6;

    // One accepted word as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] sum;
    } t_entry;

    // Absorb one byte into a reflected CRC-32 register, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

@@ sv/crcar_front.sv @@
// Front end: accepts payload words, runs the CRC and queues work for the back end.
`timescale 1ns / 1ps
module crcar_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_q_full,
    output logic               o_q_push,
    output crcar_pkg::t_entry  o_q_entry
);

    logic [31:0] r_preset;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] crc_upd;

    assign crc_upd  = crcar_pkg::crc_byte(r_crc, i_data_byte);
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        n_crc = r_crc;
        if (o_q_push) begin
            n_crc = i_last_byte ? r_preset : crc_upd;
        end
    end

    assign o_q_entry.data = i_data_byte;
    assign o_q_entry.last = i_last_byte;
    assign o_q_entry.sum  = ~crc_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= crcar_pkg::CRC_PRESET_RST;
            r_crc    <= crcar_pkg::CRC_PRESET_RST;
        end else begin
            if (i_cfg_we) begin
                r_preset <= i_cfg_wdata;
            end
            r_crc <= n_crc;
        end
    end

endmodule

@@ sv/crcar_fifo.sv @@
// Short queue of work entries between the front end and the back end.
`timescale 1ns / 1ps
module crcar_fifo #(
    parameter int P_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crcar_pkg::t_entry  i_entry,
    input  logic               i_pop,
    output crcar_pkg::t_entry  o_head,
    output logic               o_empty,
    output logic               o_full
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    crcar_pkg::t_entry r_mem [P_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ sv/crcar_back.sv @@
// Back end: sends the payload word and, after a last word, the four checksum bytes.
`timescale 1ns / 1ps
module crcar_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crcar_pkg::t_entry  i_head,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic               o_is_checksum,
    output logic               o_last_out
);

    localparam logic [2:0] PH_DATA = 3'd0;
    localparam logic [2:0] PH_SUM0 = 3'd1;
    localparam logic [2:0] PH_SUM1 = 3'd2;
    localparam logic [2:0] PH_SUM2 = 3'd3;
    localparam logic [2:0] PH_SUM3 = 3'd4;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_chk;
    logic       r_last;
    logic       load;
    logic [7:0] sel_byte;

    assign load = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        n_phase  = r_phase;
        o_q_pop  = 1'b0;
        sel_byte = i_head.data;
        unique case (r_phase)
            PH_DATA: begin
                sel_byte = i_head.data;
                if (load) begin
                    if (i_head.last) begin
                        n_phase = PH_SUM0;
                    end else begin
                        o_q_pop = 1'b1;
                    end
                end
            end
            PH_SUM0: begin
                sel_byte = i_head.sum[7:0];
                if (load) n_phase = PH_SUM1;
            end
            PH_SUM1: begin
                sel_byte = i_head.sum[15:8];
                if (load) n_phase = PH_SUM2;
            end
            PH_SUM2: begin
                sel_byte = i_head.sum[23:16];
                if (load) n_phase = PH_SUM3;
            end
            PH_SUM3: begin
                sel_byte = i_head.sum[31:24];
                if (load) begin
                    n_phase = PH_DATA;
                    o_q_pop = 1'b1;
                end
            end
            default: begin
                n_phase = PH_DATA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_chk  <= (r_phase != PH_DATA);
            r_last <= (r_phase == PH_SUM3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_is_checksum = r_chk;
    assign o_last_out    = r_last;

endmodule

@@ sv/crc32_report_checksum_appender_unit.sv @@
// Top level of the reflected CRC-32 report checksum appender.
`timescale 1ns / 1ps
// A pushed word passes through the queue and then the output register before it can be popped.
// Throughput: one word per cycle in unless the queue is full; a report-ending word yields five
// output words, so the output sets the sustained rate, one word per cycle while pop is held.
// Reset (synchronous, active low) empties the queue and output register and loads the preset
// and the running CRC with 0x1525D2B6; queued contents are not cleared.
module crc32_report_checksum_appender_unit #(
    parameter int P_FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_is_checksum,
    output logic        o_last_out
);

    // The front end folds each word into the running CRC combinationally (eight bit steps
    // unrolled) and queues the word together with the inverted CRC that would follow it.
    // The back end drains the queue and expands a report-ending word into five output words.
    crcar_pkg::t_entry q_entry;
    crcar_pkg::t_entry q_head;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;

    assign full = q_full;

    crcar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_entry)
    );

    // The queue lets input words keep arriving while the back end sends a checksum.
    crcar_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end owns the output register, so a waiting result does not hold the input
    // directly; the input stalls only once the queue behind it has filled up.
    crcar_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_is_checksum (o_is_checksum),
        .o_last_out    (o_last_out)
    );

    // The closing word of a report is always a checksum byte.
    a_last_is_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_out) |-> o_is_checksum)
        else $error("last_out on a non-checksum word");

    // Once a checksum run starts, its remaining bytes follow without a gap.
    a_checksum_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_is_checksum && !o_last_out) |=> (!empty && o_is_checksum))
        else $error("gap inside a checksum run");

    // An accepted input word is queued by the next cycle.
    a_push_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> !q_empty)
        else $error("accepted word not queued");

    // Reset leaves the output side empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the CRC-32 report checksum appender.
`timescale 1ns / 1ps
module testbench;

    // Upper bound on the whole run in ns, with the clock period at 4 ns.
    localparam longint RUN_LIMIT_NS   = 2_000_000;
    localparam int     RANDOM_ITEMS   = 185;
    localparam int     IDLE_PERCENT   = 7;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     MAX_MSG_LINES  = 40;

    // One output word as the checker expects to see it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_checksum;
        logic       last_out;
    } t_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = 32'd0;
    logic        pop         = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_out_byte;
    logic        o_is_checksum;
    logic        o_last_out;

    // Mirror of the block's register and running CRC.
    logic [31:0] preset_mirror;
    logic [31:0] running_crc;

    // Words still owed by the block, oldest first.
    t_word       pending_words[$];

    int          n_errors   = 0;
    int          n_bytes    = 0;
    int          n_reports  = 0;
    int          n_words    = 0;
    int          n_presets  = 0;
    // When low, neither side inserts random idle cycles.
    bit          gaps_on    = 1'b1;

    crc32_report_checksum_appender_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_is_checksum (o_is_checksum),
        .o_last_out    (o_last_out)
    );

    always #2 i_clk = ~i_clk;

    // Reflected CRC-32 update of one byte, one bit per iteration, LSB first.
    function automatic logic [31:0] crc_absorb(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ ({32{c[0] ^ b[k]}} & crcar_pkg::CRC_POLY);
        end
        return c;
    endfunction

    // Work out the words one accepted byte causes and queue them. A byte
    // that ends a report is followed by the inverted CRC, low byte first,
    // and the running value is then reloaded from the preset register.
    task automatic queue_expected(input logic [7:0] b, input logic lst);
        logic [31:0] sum;
        pending_words.push_back('{out_byte: b, is_checksum: 1'b0, last_out: 1'b0});
        running_crc = crc_absorb(running_crc, b);
        n_bytes++;
        if (lst) begin
            sum = ~running_crc;
            for (int k = 0; k < 4; k++) begin
                pending_words.push_back('{out_byte: sum[8*k +: 8], is_checksum: 1'b1,
                                          last_out: (k == 3)});
            end
            running_crc = preset_mirror;
            n_reports++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_MSG_LINES) begin
            $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        end
    endtask

    // Offer one byte and hold it until the block takes it. Push is only ever
    // lowered here on an idle cycle, so it is never lowered and raised again
    // in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (full);
        queue_expected(b, lst);
    endtask

    // Send a whole report; the final byte carries the last flag.
    task automatic send_report(input logic [7:0] bytes_in[$]);
        foreach (bytes_in[i]) begin
            send_byte(bytes_in[i], i == bytes_in.size() - 1);
        end
    endtask

    // Drop push and hold off until every owed word has been popped.
    task automatic drain_output();
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // The preset is only written while the block has nothing in flight.
    task automatic write_preset(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        preset_mirror = value;
        n_presets++;
    endtask

    // Output side: every popped word is checked against the oldest
    // expectation, and pop is dropped now and then to stall the block.
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_words++;
                if (pending_words.size() == 0) begin
                    report_mismatch("word with nothing expected, out_byte",
                                    32'(o_out_byte), 32'd0);
                end else begin
                    want = pending_words.pop_front();
                    if (o_out_byte !== want.out_byte)
                        report_mismatch("out_byte", 32'(o_out_byte), 32'(want.out_byte));
                    if (o_is_checksum !== want.is_checksum)
                        report_mismatch("is_checksum", 32'(o_is_checksum),
                                        32'(want.is_checksum));
                    if (o_last_out !== want.last_out)
                        report_mismatch("last_out", 32'(o_last_out), 32'(want.last_out));
                end
            end
            pop <= !(gaps_on && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // A preset written before any report must not affect the first report,
    // which still starts from the reset value; the second one uses it.
    task automatic test_preset_before_first_report();
        write_preset(32'hFFFF_FFFF);
        send_report('{8'h31, 8'hC4});
        send_report('{8'h7E});
        drain_output();
    endtask

    // Byte extremes, alternating bit patterns and one-byte reports.
    task automatic test_byte_extremes();
        send_report('{8'h00});
        send_report('{8'hFF});
        send_report('{8'h00, 8'hFF, 8'h55, 8'hAA});
        drain_output();
    endtask

    // A preset change in the middle of a report leaves the running CRC
    // alone; it only shows up after the report has ended.
    task automatic test_preset_mid_report();
        send_byte(8'h12, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        drain_output();
        write_preset(32'h0000_0000);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_report('{8'h9B});
        drain_output();
    endtask

    // Walk the preset through its extremes and back to the reset value.
    task automatic test_preset_sweep();
        logic [31:0] presets[4];
        presets = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5C3_0F96, crcar_pkg::CRC_PRESET_RST};
        foreach (presets[i]) begin
            write_preset(presets[i]);
            send_report('{8'hA2, 8'h5D});
            drain_output();
        end
    endtask

    // Random reports, mostly short with a few long ones. The middle third
    // runs with no idle cycles on either side. Now and then the sender
    // waits for the output to drain and loads a new preset.
    task automatic test_random_reports();
        logic [7:0] report[$];
        int         sent;
        int         len;
        logic [31:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            gaps_on = !(sent >= RANDOM_ITEMS / 3 && sent < 2 * RANDOM_ITEMS / 3);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 8);
            report.delete();
            for (int i = 0; i < len; i++) report.push_back(8'($urandom_range(0, 255)));
            send_report(report);
            sent += len;
            if ($urandom_range(0, 5) == 0) begin
                drain_output();
                case ($urandom_range(0, 3))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                write_preset(value);
            end
        end
        gaps_on = 1'b1;
        drain_output();
    endtask

    initial begin
        preset_mirror = crcar_pkg::CRC_PRESET_RST;
        running_crc   = crcar_pkg::CRC_PRESET_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_preset_before_first_report();
        test_byte_extremes();
        test_preset_mid_report();
        test_preset_sweep();
        test_random_reports();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0)
            report_mismatch("words never delivered, count", pending_words.size(), 32'd0);

        $display("Run covered %0d payload bytes in %0d reports and %0d output words,",
                 n_bytes, n_reports, n_words);
        $display("with %0d preset loads and %0d mismatching fields.", n_presets, n_errors);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d words still expected.", pending_words.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ crc32_report_checksum_appender_unit.f @@
sv/crcar_pkg.sv
sv/crcar_front.sv
sv/crcar_fifo.sv
sv/crcar_back.sv
sv/crc32_report_checksum_appender_unit.sv
tb/sv/testbench.sv
